@@ hdl/gbc_pkg.sv @@
// Package for the gyro bias calibrator: widths, derived constants and types.
// Shared by gbc_lane, gbc_merge and gyro_bias_calibrator; depends on nothing.
package gbc_pkg;

    localparam int NUM_AXES   = 3;
    localparam int RAW_W      = 16;
    localparam int FRAC_W     = 10;
    localparam int BIAS_W     = 26;
    localparam int LIM_W      = 41;
    localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(5000);

    localparam int WINDOW_LEN = 1024;
    localparam int LOG_N      = $clog2(WINDOW_LEN);
    localparam int CNT_W      = LOG_N;
    localparam logic [CNT_W-1:0] WIN_LAST = CNT_W'(WINDOW_LEN - 1);
    localparam int N_W        = LOG_N + 1;
    localparam logic [N_W-1:0] WIN_N = N_W'(WINDOW_LEN);

    localparam int SUM_W      = RAW_W + LOG_N;
    localparam int MAG_W      = SUM_W;
    localparam int SQR_W      = 2 * RAW_W - 1;
    localparam int SQ_W       = SQR_W + LOG_N;
    localparam int XP_W       = SQ_W + 1;
    localparam int DIF_W      = ((SQ_W > LIM_W) ? SQ_W : LIM_W) + 1;
    localparam int CMP_W      = XP_W + N_W;

    localparam int RCP_W      = MAG_W + FRAC_W;
    localparam logic [RCP_W-1:0] RCP = RCP_W'((64'd1 << (MAG_W + FRAC_W)) / WINDOW_LEN);
    localparam int RLO_W      = RCP_W / 2;
    localparam int RHI_W      = RCP_W - RLO_W;
    localparam logic [RLO_W-1:0] RCP_LO = RCP[RLO_W-1:0];
    localparam logic [RHI_W-1:0] RCP_HI = RCP[RCP_W-1:RLO_W];
    localparam int PROD_W     = MAG_W + RCP_W;
    localparam int QUO_W      = BIAS_W;
    localparam int DIV_W      = MAG_W + FRAC_W;
    localparam int COR_W      = BIAS_W + 2;

    localparam int PIPE_LEN   = 8;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam logic [FIFO_AW:0] FIFO_FULL = (FIFO_AW + 1)'(FIFO_DEPTH);

    localparam int DATA_W     = 64;
    localparam int PADDR_W    = 4;
    localparam logic REG_LIMIT = 1'b0;

    typedef struct packed {
        logic acc;
        logic last;
    } t_lane_ctl;

    typedef struct packed {
        logic signed [RAW_W-1:0]  raw;
        logic                     quiet;
        logic signed [BIAS_W-1:0] bias;
    } t_lane_out;

    typedef struct packed {
        logic [NUM_AXES-1:0][RAW_W-1:0]  corr;
        logic                            cal;
        logic [NUM_AXES-1:0][BIAS_W-1:0] offset;
    } t_result;

endpackage

@@ hdl/gbc_lane.sv @@
// One axis lane: running sum and sum of squares, window variance test and window mean.
// Depends on gbc_pkg for widths, reciprocal constants and the lane structs.
module gbc_lane import gbc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic signed [RAW_W-1:0] i_raw,
    input  t_lane_ctl               i_ctl,
    input  logic [LIM_W-1:0]        i_limit,
    output t_lane_out               o_lane
);

    logic signed [2*RAW_W-1:0] raw_sq;
    logic signed [SUM_W-1:0]   n_sum;
    logic [SQ_W-1:0]           n_sq;
    logic [SUM_W-1:0]          sum_neg;
    logic [DIF_W-1:0]          ext_sq;
    logic [DIF_W-1:0]          ext_lim;
    logic [DIF_W-1:0]          dif;
    logic [2*MAG_W-1:0]        mag_sq;
    logic [CMP_W-1:0]          nx;
    logic [MAG_W+RLO_W-1:0]    plo;
    logic [MAG_W+RHI_W-1:0]    phi;
    logic [PROD_W-1:0]         prod;
    logic [DIV_W-1:0]          qn;
    logic [DIV_W-1:0]          rem;

    logic signed [SUM_W-1:0]   r_sum;
    logic [SQ_W-1:0]           r_sq;

    logic signed [RAW_W-1:0]   r_p0_raw, r_p1_raw, r_p2_raw, r_p3_raw;
    logic signed [RAW_W-1:0]   r_p4_raw, r_p5_raw, r_p6_raw, r_p7_raw;
    logic [SQR_W-1:0]          r_p0_sqr;
    logic signed [SUM_W-1:0]   r_p1_sum;
    logic [SQ_W-1:0]           r_p1_sq;
    logic [MAG_W-1:0]          r_p2_mag, r_p3_mag, r_p4_mag, r_p5_mag;
    logic                      r_p2_neg, r_p3_neg, r_p4_neg, r_p5_neg, r_p6_neg;
    logic                      r_p2_small, r_p3_small;
    logic [XP_W-1:0]           r_p2_xp1;
    logic [CMP_W-1:0]          r_p3_sq;
    logic [CMP_W-1:0]          r_p3_nx;
    logic [MAG_W+RLO_W-1:0]    r_p3_plo;
    logic [MAG_W+RHI_W-1:0]    r_p3_phi;
    logic                      r_p4_quiet, r_p5_quiet, r_p6_quiet, r_p7_quiet;
    logic [QUO_W-1:0]          r_p4_q0, r_p5_q0, r_p6_q1;
    logic [DIV_W-1:0]          r_p5_qn;
    logic signed [BIAS_W-1:0]  r_p7_bias;

    assign raw_sq  = i_raw * i_raw;
    assign n_sum   = r_sum + SUM_W'(r_p0_raw);
    assign n_sq    = r_sq + SQ_W'(r_p0_sqr);
    assign sum_neg = -r_p1_sum;
    assign ext_sq  = DIF_W'(r_p1_sq);
    assign ext_lim = DIF_W'(i_limit);
    assign dif     = ext_sq - ext_lim + DIF_W'(1);
    assign mag_sq  = r_p2_mag * r_p2_mag;
    assign nx      = r_p2_xp1 * WIN_N;
    assign plo     = r_p2_mag * RCP_LO;
    assign phi     = r_p2_mag * RCP_HI;
    assign prod    = PROD_W'(r_p3_plo) + (PROD_W'(r_p3_phi) << RLO_W);
    assign qn      = r_p4_q0 * WIN_N;
    assign rem     = {r_p5_mag, {FRAC_W{1'b0}}} - r_p5_qn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_sq  <= '0;
        end else if (i_ctl.acc) begin
            r_sum <= i_ctl.last ? '0 : n_sum;
            r_sq  <= i_ctl.last ? '0 : n_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0_raw   <= i_raw;
        r_p0_sqr   <= raw_sq[SQR_W-1:0];

        r_p1_raw   <= r_p0_raw;
        r_p1_sum   <= n_sum;
        r_p1_sq    <= n_sq;

        r_p2_raw   <= r_p1_raw;
        r_p2_neg   <= r_p1_sum[SUM_W-1];
        r_p2_mag   <= r_p1_sum[SUM_W-1] ? MAG_W'(sum_neg) : MAG_W'(unsigned'(r_p1_sum));
        r_p2_small <= ext_sq < ext_lim;
        r_p2_xp1   <= dif[XP_W-1:0];

        r_p3_raw   <= r_p2_raw;
        r_p3_neg   <= r_p2_neg;
        r_p3_mag   <= r_p2_mag;
        r_p3_small <= r_p2_small;
        r_p3_sq    <= CMP_W'(mag_sq);
        r_p3_nx    <= nx;
        r_p3_plo   <= plo;
        r_p3_phi   <= phi;

        r_p4_raw   <= r_p3_raw;
        r_p4_neg   <= r_p3_neg;
        r_p4_mag   <= r_p3_mag;
        r_p4_quiet <= r_p3_small || (r_p3_sq >= r_p3_nx);
        r_p4_q0    <= prod[MAG_W +: QUO_W];

        r_p5_raw   <= r_p4_raw;
        r_p5_neg   <= r_p4_neg;
        r_p5_mag   <= r_p4_mag;
        r_p5_quiet <= r_p4_quiet;
        r_p5_q0    <= r_p4_q0;
        r_p5_qn    <= qn;

        r_p6_raw   <= r_p5_raw;
        r_p6_neg   <= r_p5_neg;
        r_p6_quiet <= r_p5_quiet;
        r_p6_q1    <= r_p5_q0 + QUO_W'(rem >= DIV_W'(WINDOW_LEN));

        r_p7_raw   <= r_p6_raw;
        r_p7_quiet <= r_p6_quiet;
        r_p7_bias  <= r_p6_neg ? -signed'(r_p6_q1) : signed'(r_p6_q1);
    end

    assign o_lane.raw   = r_p7_raw;
    assign o_lane.quiet = r_p7_quiet;
    assign o_lane.bias  = r_p7_bias;

endmodule

@@ hdl/gbc_merge.sv @@
// Merging stage: combines the lane verdicts, latches the bias and forms the result word.
// Depends on gbc_pkg for the lane and result structs.
module gbc_merge import gbc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_lane_out [NUM_AXES-1:0]      i_lane,
    input  logic                          i_valid,
    input  logic                          i_last,
    output logic                          o_wr,
    output t_result                       o_word,
    output logic                          o_locked
);

    localparam logic signed [COR_W-1:0] RND = COR_W'((1 << FRAC_W) - 1);

    logic                            r_locked;
    logic [NUM_AXES-1:0][BIAS_W-1:0] r_bias;
    logic                            all_quiet;
    logic                            n_lock;

    function automatic logic [RAW_W-1:0] correct(input logic signed [RAW_W-1:0] raw,
                                                 input logic signed [BIAS_W-1:0] bias);
        logic signed [COR_W-1:0] d;
        logic signed [COR_W-1:0] t;
        logic signed [COR_W-1:0] q;
        logic [COR_W-RAW_W:0]    hi;
        logic [RAW_W-1:0]        res;
        d  = (COR_W'(raw) <<< FRAC_W) - COR_W'(bias);
        t  = d + (d[COR_W-1] ? RND : '0);
        q  = t >>> FRAC_W;
        hi = q[COR_W-1:RAW_W-1];
        if (hi == '0 || hi == '1) begin
            res = q[RAW_W-1:0];
        end else if (q[COR_W-1]) begin
            res = {1'b1, {(RAW_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(RAW_W-1){1'b1}}};
        end
        return res;
    endfunction

    always_comb begin
        all_quiet = 1'b1;
        for (int k = 0; k < NUM_AXES; k++) begin
            all_quiet = all_quiet & i_lane[k].quiet;
        end
    end

    assign n_lock = i_valid && i_last && !r_locked && all_quiet;

    always_comb begin
        o_word.cal = r_locked | n_lock;
        for (int k = 0; k < NUM_AXES; k++) begin
            o_word.corr[k]   = correct(i_lane[k].raw, signed'(r_bias[k]));
            o_word.offset[k] = n_lock ? unsigned'(i_lane[k].bias) : r_bias[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked <= 1'b0;
            r_bias   <= '0;
        end else if (n_lock) begin
            r_locked <= 1'b1;
            for (int k = 0; k < NUM_AXES; k++) begin
                r_bias[k] <= unsigned'(i_lane[k].bias);
            end
        end
    end

    assign o_wr     = i_valid;
    assign o_locked = r_locked;

endmodule

@@ hdl/gyro_bias_calibrator.sv @@
// Top level of the gyro bias calibrator: configuration port, window counter,
// three axis lanes, the merging stage and the output queue. Depends on gbc_pkg.
//
// Usage: each input word carries one three-axis gyro sample and is taken at a rising
// edge with i_valid high and o_stall low. Each sample yields exactly one output word
// with the bias-corrected rates, the calibrated flag and the current bias of each axis.
// Samples are summed over windows of WINDOW_LEN samples; a window whose variance is
// below variance_limit on all three axes sets the bias to the window mean and locks it.
// Each word passes the registered lane stages and the output queue before it is taken.
// Throughput is one word per cycle while o_stall and i_stall are low; each lane is an
// eight-stage pipeline whose squaring, variance and mean multipliers each take one
// stage. Results wait in a 16-word queue; o_stall rises when 16 words are in flight or
// queued, so the block keeps taking samples while a stalled result waits. Reset clears
// the sums, the window count, the bias and the calibrated flag and sets variance_limit
// to 5000; there is no clearing pass. The user must write variance_limit over the APB
// port at byte address 0 only while no sample is in flight; the block does not check.
module gyro_bias_calibrator import gbc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [RAW_W-1:0]  i_rate_x,
    input  logic signed [RAW_W-1:0]  i_rate_y,
    input  logic signed [RAW_W-1:0]  i_rate_z,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [RAW_W-1:0]  o_corrected_x,
    output logic signed [RAW_W-1:0]  o_corrected_y,
    output logic signed [RAW_W-1:0]  o_corrected_z,
    output logic                     o_calibrated,
    output logic signed [BIAS_W-1:0] o_offset_x,
    output logic signed [BIAS_W-1:0] o_offset_y,
    output logic signed [BIAS_W-1:0] o_offset_z,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    logic [LIM_W-1:0]         r_limit;
    logic [PIPE_LEN-1:0]      r_vld;
    logic [PIPE_LEN-2:0]      r_end;
    logic [CNT_W-1:0]         r_win;
    t_result                  r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]       r_wptr;
    logic [FIFO_AW-1:0]       r_rptr;
    logic [FIFO_AW:0]         r_cnt;
    logic [FIFO_AW:0]         r_occ;

    logic                     w_in_acc;
    logic                     w_out_acc;
    logic                     w_last;
    logic                     w_reg_sel;
    t_lane_ctl                w_ctl;
    logic signed [RAW_W-1:0]  w_raw [NUM_AXES];
    t_lane_out [NUM_AXES-1:0] w_lane;
    logic                     w_wr;
    t_result                  w_word;
    t_result                  w_head;
    logic                     w_locked;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;
    assign w_last    = (r_win == WIN_LAST);
    assign w_ctl.acc  = r_vld[0];
    assign w_ctl.last = w_last;

    assign w_reg_sel = (paddr[PADDR_W-1] == REG_LIMIT);
    assign pready    = 1'b1;
    assign prdata    = w_reg_sel ? DATA_W'(r_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIM_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_limit <= pwdata[LIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_end <= '0;
            r_win <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LEN-2:0], w_in_acc};
            r_end <= {r_end[PIPE_LEN-3:0], r_vld[0] && w_last};
            if (r_vld[0]) begin
                r_win <= w_last ? '0 : r_win + 1'b1;
            end
        end
    end

    assign w_raw[0] = i_rate_x;
    assign w_raw[1] = i_rate_y;
    assign w_raw[2] = i_rate_z;

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        gbc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_raw   (w_raw[g]),
            .i_ctl   (w_ctl),
            .i_limit (r_limit),
            .o_lane  (w_lane[g])
        );
    end

    gbc_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_lane   (w_lane),
        .i_valid  (r_vld[PIPE_LEN-1]),
        .i_last   (r_end[PIPE_LEN-2]),
        .o_wr     (w_wr),
        .o_word   (w_word),
        .o_locked (w_locked)
    );

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_fifo[r_wptr] <= w_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
            r_occ  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_out_acc) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + (FIFO_AW + 1)'(w_wr) - (FIFO_AW + 1)'(w_out_acc);
            r_occ <= r_occ + (FIFO_AW + 1)'(w_in_acc) - (FIFO_AW + 1)'(w_out_acc);
        end
    end

    assign w_head  = r_fifo[r_rptr];
    assign o_valid = (r_cnt != '0);
    assign o_stall = (r_occ == FIFO_FULL);

    assign o_corrected_x = signed'(w_head.corr[0]);
    assign o_corrected_y = signed'(w_head.corr[1]);
    assign o_corrected_z = signed'(w_head.corr[2]);
    assign o_calibrated  = w_head.cal;
    assign o_offset_x    = signed'(w_head.offset[0]);
    assign o_offset_y    = signed'(w_head.offset[1]);
    assign o_offset_z    = signed'(w_head.offset[2]);

    a_lock_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_locked |=> w_locked)
        else $error("calibrated flag dropped after lock");

    a_occ_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_occ) == int'(r_cnt) + $countones(r_vld))
        else $error("in-flight count disagrees with pipeline and queue contents");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |-> (r_cnt != FIFO_FULL))
        else $error("result queue written while full");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for gyro_bias_calibrator: drives gyro sample words and APB register accesses,
// predicts every output word on its own and compares each one field by field.
// Depends on gbc_pkg and the gyro_bias_calibrator RTL; it reads no files.
module testbench;
    import gbc_pkg::*;

    typedef logic [NUM_AXES-1:0][RAW_W-1:0] t_triple;
    typedef longint unsigned t_u64;

    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int DRAIN_CYCLES   = 30;
    localparam logic [PADDR_W-1:0] LIMIT_ADDR = PADDR_W'(8 * REG_LIMIT);
    // No register is mapped at this address.
    localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(8 * (REG_LIMIT + 1));
    localparam logic [LIM_W-1:0] LIMIT_AT_RESET = LIM_W'(5000);
    localparam longint SCALE   = longint'(1) << FRAC_W;
    localparam longint RAW_MAX = (longint'(1) << (RAW_W - 1)) - 1;
    localparam longint RAW_MIN = -(longint'(1) << (RAW_W - 1));

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic signed [RAW_W-1:0]  i_rate_x = '0;
    logic signed [RAW_W-1:0]  i_rate_y = '0;
    logic signed [RAW_W-1:0]  i_rate_z = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [RAW_W-1:0]  o_corrected_x;
    logic signed [RAW_W-1:0]  o_corrected_y;
    logic signed [RAW_W-1:0]  o_corrected_z;
    logic                     o_calibrated;
    logic signed [BIAS_W-1:0] o_offset_x;
    logic signed [BIAS_W-1:0] o_offset_y;
    logic signed [BIAS_W-1:0] o_offset_z;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    t_result expected_words [$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      src_idle_pct = 0;
    int      sink_idle_pct = 0;
    int      sink_hold = 0;
    string   axis_tag [NUM_AXES] = '{"x", "y", "z"};

    logic [LIM_W-1:0] limit_model;
    longint           win_sum [NUM_AXES];
    t_u64             win_sq [NUM_AXES];
    int               win_count;
    bit               bias_held;
    longint           axis_offset [NUM_AXES];
    longint           quiet_mean [NUM_AXES];
    int               quiet_span [NUM_AXES];

    gyro_bias_calibrator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rate_x      (i_rate_x),
        .i_rate_y      (i_rate_y),
        .i_rate_z      (i_rate_z),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_corrected_x (o_corrected_x),
        .o_corrected_y (o_corrected_y),
        .o_corrected_z (o_corrected_z),
        .o_calibrated  (o_calibrated),
        .o_offset_x    (o_offset_x),
        .o_offset_y    (o_offset_y),
        .o_offset_z    (o_offset_z),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < sink_idle_pct) begin
            sink_hold <= $urandom_range(0, 11);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic void clear_window_model();
        for (int a = 0; a < NUM_AXES; a++) begin
            win_sum[a] = 0;
            win_sq[a] = 0;
        end
        win_count = 0;
    endfunction

    // Sum of squared deviations of one axis over the open window as if sample s were added to it.
    function automatic t_u64 window_spread(input int a, input t_triple s);
        longint r;
        longint sum;
        t_u64   sq;
        r = longint'($signed(s[a]));
        sum = win_sum[a] + r;
        sq = win_sq[a] + t_u64'(r * r);
        return sq - t_u64'((sum * sum) / WINDOW_LEN);
    endfunction

    function automatic t_u64 worst_spread(input t_triple s);
        t_u64 top;
        t_u64 v;
        top = 0;
        for (int a = 0; a < NUM_AXES; a++) begin
            v = window_spread(a, s);
            if (v > top) top = v;
        end
        return top;
    endfunction

    function automatic void predict_word(input t_triple s);
        t_result w;
        longint  r;
        longint  d;
        bit      closing;
        bit      quiet_window;
        closing = !bias_held && (win_count == WINDOW_LEN - 1);
        quiet_window = 1'b1;
        for (int a = 0; a < NUM_AXES; a++) begin
            r = longint'($signed(s[a]));
            d = (r * SCALE - axis_offset[a]) / SCALE;
            if (d > RAW_MAX) d = RAW_MAX;
            if (d < RAW_MIN) d = RAW_MIN;
            w.corr[a] = d[RAW_W-1:0];
            if (closing && !(window_spread(a, s) < limit_model)) quiet_window = 1'b0;
        end
        if (!bias_held) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r = longint'($signed(s[a]));
                win_sum[a] += r;
                win_sq[a] += t_u64'(r * r);
            end
            win_count++;
            if (closing) begin
                if (quiet_window) begin
                    for (int a = 0; a < NUM_AXES; a++)
                        axis_offset[a] = (win_sum[a] * SCALE) / WINDOW_LEN;
                    bias_held = 1'b1;
                end else begin
                    clear_window_model();
                end
            end
        end
        w.cal = bias_held;
        for (int a = 0; a < NUM_AXES; a++)
            w.offset[a] = axis_offset[a][BIAS_W-1:0];
        expected_words.push_back(w);
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        t_result seen;
        if (i_rst_n && o_valid && !i_stall) begin
            seen.corr = {o_corrected_z, o_corrected_y, o_corrected_x};
            seen.cal = o_calibrated;
            seen.offset = {o_offset_z, o_offset_y, o_offset_x};
            if (expected_words.size() == 0) begin
                $error("output word arrived with none expected");
                error_count++;
            end else begin
                want = expected_words.pop_front();
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (seen.corr[a] !== want.corr[a]) begin
                        $error("corrected_%s: expected %0d, got %0d", axis_tag[a],
                               $signed(want.corr[a]), $signed(seen.corr[a]));
                        error_count++;
                    end
                    if (seen.offset[a] !== want.offset[a]) begin
                        $error("offset_%s: expected %0d, got %0d", axis_tag[a],
                               $signed(want.offset[a]), $signed(seen.offset[a]));
                        error_count++;
                    end
                end
                if (seen.cal !== want.cal) begin
                    $error("calibrated: expected %0d, got %0d", want.cal, seen.cal);
                    error_count++;
                end
            end
        end
    end

    task automatic send_sample(input t_triple s);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_rate_x <= s[0];
        i_rate_y <= s[1];
        i_rate_z <= s[2];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_word(s);
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == LIMIT_ADDR) limit_model = data[LIM_W-1:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_limit_readback();
        logic [DATA_W-1:0] got;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= LIMIT_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata;
        if (got !== DATA_W'(limit_model)) begin
            $error("variance_limit: expected %0d, got %0d", limit_model, got);
            error_count++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_triple any_sample();
        t_triple s;
        for (int a = 0; a < NUM_AXES; a++)
            s[a] = RAW_W'($urandom);
        return s;
    endfunction

    function automatic t_triple quiet_sample();
        t_triple s;
        longint  v;
        for (int a = 0; a < NUM_AXES; a++) begin
            v = quiet_mean[a] + longint'($urandom_range(0, 2 * quiet_span[a])) - quiet_span[a];
            if (v > RAW_MAX) v = RAW_MAX;
            if (v < RAW_MIN) v = RAW_MIN;
            s[a] = v[RAW_W-1:0];
        end
        return s;
    endfunction

    task automatic test_register_access();
        check_limit_readback();
        reg_write(LIMIT_ADDR, '0);
        check_limit_readback();
        reg_write(LIMIT_ADDR, DATA_W'(LIMIT_AT_RESET));
        check_limit_readback();
    endtask

    task automatic test_field_extremes();
        logic [RAW_W-1:0] corner_vals [9];
        src_idle_pct = 20;
        sink_idle_pct = 20;
        corner_vals = '{16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000,
                        16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00};
        foreach (corner_vals[i])
            send_sample({corner_vals[i], corner_vals[i], corner_vals[i]});
        send_sample({16'h0000, 16'h8000, 16'h7FFF});
        send_sample({16'h8000, 16'h7FFF, 16'h0000});
        send_sample({16'h7FFF, 16'h0000, 16'h8000});
    endtask

    // The noisiest axis lands exactly on the limit, so this window must be rejected.
    task automatic test_rejected_window();
        t_triple last;
        src_idle_pct = 25;
        sink_idle_pct = 25;
        while (win_count < WINDOW_LEN - 1) begin
            if (win_count > WINDOW_LEN / 2) begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            send_sample(any_sample());
        end
        wait_quiet();
        last = any_sample();
        reg_write(LIMIT_ADDR, DATA_W'(worst_spread(last)));
        check_limit_readback();
        send_sample(last);
    endtask

    // Low noise around large x and y means; the limit sits one above the worst spread.
    task automatic test_accepted_window();
        t_triple last;
        wait_quiet();
        quiet_mean[0] = -20000 - longint'($urandom_range(0, 8000));
        quiet_mean[1] = 20000 + longint'($urandom_range(0, 8000));
        quiet_mean[2] = longint'($urandom_range(0, 60000)) - 30000;
        quiet_span[0] = $urandom_range(0, 40);
        quiet_span[1] = $urandom_range(1, 40);
        quiet_span[2] = $urandom_range(1, 40);
        src_idle_pct = 0;
        sink_idle_pct = 40;
        while (win_count < WINDOW_LEN - 1) begin
            if (win_count == WINDOW_LEN / 2) begin
                src_idle_pct = 30;
                sink_idle_pct = 10;
            end
            send_sample(quiet_sample());
        end
        wait_quiet();
        last = quiet_sample();
        reg_write(LIMIT_ADDR, DATA_W'(worst_spread(last) + 1));
        check_limit_readback();
        send_sample(last);
    endtask

    task automatic test_locked_bias();
        wait_quiet();
        reg_write(LIMIT_ADDR, '1);
        check_limit_readback();
        reg_write(SPARE_ADDR, {$urandom, $urandom});
        check_limit_readback();
        src_idle_pct = 30;
        sink_idle_pct = 30;
        send_sample({16'h0000, 16'h8000, 16'h7FFF});
        send_sample({16'h8000, 16'h8000, 16'h8000});
        send_sample({16'h7FFF, 16'h7FFF, 16'h7FFF});
        for (int i = 0; i < 40; i++)
            send_sample(quiet_sample());
        for (int i = 0; i < 150; i++)
            send_sample(any_sample());
        src_idle_pct = 0;
        sink_idle_pct = 0;
        for (int i = 0; i < 100; i++)
            send_sample(($urandom_range(0, 3) == 0) ? quiet_sample() : any_sample());
    endtask

    initial begin
        limit_model = LIMIT_AT_RESET;
        clear_window_model();
        bias_held = 1'b0;
        for (int a = 0; a < NUM_AXES; a++)
            axis_offset[a] = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_register_access();
        test_field_extremes();
        test_rejected_window();
        test_accepted_window();
        test_locked_bias();
        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ gyro_bias_calibrator.f @@
hdl/gbc_pkg.sv
hdl/gbc_lane.sv
hdl/gbc_merge.sv
hdl/gyro_bias_calibrator.sv
dv/testbench.sv
